// ----- rtl/core/bmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_pkg - shared types and constants of the majority vote bundler
// Request codes, stream field positions, controller states and the result
// information that passes from the controller to the merge stage.
// ----------------------------------------------------------------------------
package bmv_pkg;

   // fixed field widths of the stream items
   localparam int INDEX_BITS = 6;
   localparam int DATA_BITS  = 64;
   localparam int TOTAL_BITS = 13;
   localparam int KIND_BITS  = 2;
   localparam int WORD_SLOTS = 64;

   // request tdata layout, lowest bit first
   localparam int REQ_INDEX_LSB  = 0;
   localparam int REQ_DATA_LSB   = REQ_INDEX_LSB + INDEX_BITS;
   localparam int REQ_TOTAL_LSB  = REQ_DATA_LSB + DATA_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_TOTAL_LSB + TOTAL_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int RSP_VOTE_LSB   = 0;
   localparam int RSP_ECHO_LSB   = RSP_VOTE_LSB + DATA_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_ECHO_LSB + INDEX_BITS + 7) / 8) * 8;

   // request kinds
   localparam logic [KIND_BITS-1:0] REQ_CLEAR      = 2'd0;
   localparam logic [KIND_BITS-1:0] REQ_ACCUMULATE = 2'd1;
   localparam logic [KIND_BITS-1:0] REQ_THRESHOLD  = 2'd2;
   localparam logic [KIND_BITS-1:0] REQ_INVALID    = 2'd3;

   // response status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_KIND = 1'b1;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // what the merge stage needs to build a response
   typedef struct packed {
      logic [INDEX_BITS-1:0] word_echo;
      logic                  status;
      logic                  vote_en;
   } rsp_info_type;

endpackage

// ----- rtl/core/bmv_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmv_ram #(
   parameter int WIDTH = 832,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bmv_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_lane - one bit lane of the bundler
// Saturating increment of the lane counter and the majority compare.
// ----------------------------------------------------------------------------
module bmv_lane #(
   parameter int COUNT_BITS = 13
) (
   input  logic                           present,
   input  logic [COUNT_BITS-1:0]          count,
   input  logic                           data_bit,
   input  logic [bmv_pkg::TOTAL_BITS-1:0] threshold,
   output logic [COUNT_BITS-1:0]          count_next,
   output logic                           vote
);
   import bmv_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

   logic [COUNT_BITS-1:0] base;
   logic                  at_top;

   // a word not yet written reads as zero counts
   assign base   = present ? count : '0;
   assign at_top = &base;

   // saturating increment
   always_comb begin
      if (data_bit && !at_top) begin
         count_next = COUNT_BITS'(base + 1'b1);
      end else begin
         count_next = base;
      end
   end

   // strict majority compare on the stored count
   assign vote = CMP_BITS'(base) >= CMP_BITS'(threshold);

endmodule

// ----- rtl/core/bmv_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_merge - lane merge and response register
// Gathers the lane votes into the response word and holds it on the
// response stream until the transfer completes.
// ----------------------------------------------------------------------------
module bmv_merge #(
   parameter int LANES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  bmv_pkg::rsp_info_type              info,
   input  logic [LANES-1:0]                   lane_vote,
   output logic                               slot_free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bmv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // vote_word, word_echo, zero pad
   output logic [0:0]                         rsp_tuser   // status
);
   import bmv_pkg::*;

   logic [DATA_BITS-1:0]  vote_all;
   logic [DATA_BITS-1:0]  vote_in;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [DATA_BITS-1:0]  vote_ff;
   logic [INDEX_BITS-1:0] echo_ff;
   logic                  status_ff;

   // spread lane votes over the word, lanes past the count read zero
   for (genvar i = 0; i < DATA_BITS; i++) begin : g_spread
      if (i < LANES) begin : g_lane
         assign vote_all[i] = lane_vote[i];
      end else begin : g_none
         assign vote_all[i] = 1'b0;
      end
   end

   assign vote_in   = info.vote_en ? vote_all : '0;
   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   // response valid
   always_comb begin
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         vote_ff   <= vote_in;
         echo_ff   <= info.word_echo;
         status_ff <= info.status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_VOTE_LSB +: DATA_BITS]  = vote_ff;
      rsp_tdata[RSP_ECHO_LSB +: INDEX_BITS] = echo_ff;
   end
   assign rsp_tuser = status_ff;

endmodule

// ----- rtl/core/bitwise_majority_vote_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitwise_majority_vote_top - majority vote bundler for binary hypervectors
// Keeps a saturating counter per bit position and answers majority words.
// ----------------------------------------------------------------------------
// Each request passes the idle and the lookup state: in idle the request is
// taken and the word's counters are read from the count RAM, in lookup LANES
// lanes update or compare them in parallel, the accumulated word is written
// back and the response is loaded. The read-modify-write through the single
// count RAM sets this order; one request at a time is taken, a new one from the cycle
// after the response is loaded, while that response waits in its register.
// A clear resets the whole per-word valid mask, no sweep of the RAM.
// A stalled response holds the lookup state until its register is free.
// ----------------------------------------------------------------------------
module bitwise_majority_vote_top #(
   parameter int VECTOR_BITS = 4096,
   parameter int LANES       = 64,
   parameter int COUNT_BITS  = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bmv_pkg::REQ_TDATA_BITS-1:0] req_tdata,  // word_index, data_word,
                                                          // member_total, zero pad
   input  logic [bmv_pkg::KIND_BITS-1:0]      req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bmv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // vote_word, word_echo, zero pad
   output logic [0:0]                         rsp_tuser   // status
);
   import bmv_pkg::*;

   localparam int RAW_WORDS = VECTOR_BITS / LANES;
   localparam int NUM_WORDS = (RAW_WORDS < WORD_SLOTS) ? RAW_WORDS : WORD_SLOTS;
   localparam int ADDR_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int ROW_BITS  = LANES * COUNT_BITS;

   state_type               state_ff;
   state_type               state_in;
   logic [NUM_WORDS-1:0]    word_valid_ff;
   logic [NUM_WORDS-1:0]    word_valid_in;

   logic [KIND_BITS-1:0]    kind_ff;
   logic [INDEX_BITS-1:0]   word_ff;
   logic [LANES-1:0]        data_ff;
   logic [TOTAL_BITS-1:0]   total_ff;

   logic                    req_fire;
   logic                    slot_free;
   logic                    ram_rd_en;
   logic                    ram_we;
   logic                    rsp_load;
   logic                    valid_set;
   logic                    valid_clear;
   logic                    in_range;
   logic                    present;
   logic [ADDR_BITS-1:0]    word_addr;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [TOTAL_BITS-1:0]   threshold;
   logic [ROW_BITS-1:0]     row_rd;
   logic [ROW_BITS-1:0]     row_wr;
   logic [LANES-1:0]        lane_vote;
   rsp_info_type            info;

   assign req_fire = req_tvalid && req_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_tuser;
         word_ff  <= req_tdata[REQ_INDEX_LSB +: INDEX_BITS];
         data_ff  <= req_tdata[REQ_DATA_LSB +: LANES];
         total_ff <= req_tdata[REQ_TOTAL_LSB +: TOTAL_BITS];
      end
   end

   // word decode
   assign in_range  = {1'b0, word_ff} < (INDEX_BITS + 1)'(NUM_WORDS);
   assign word_addr = word_ff[ADDR_BITS-1:0];
   assign rd_addr   = req_tdata[REQ_INDEX_LSB +: ADDR_BITS];
   assign present   = in_range && word_valid_ff[word_addr];
   assign threshold = TOTAL_BITS'({1'b0, total_ff[TOTAL_BITS-1:1]} + 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready  = 1'b0;
      ram_rd_en   = 1'b0;
      ram_we      = 1'b0;
      rsp_load    = 1'b0;
      valid_set   = 1'b0;
      valid_clear = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_rd_en  = req_tvalid;
         end
         ST_LOOKUP: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               ram_we      = (kind_ff == REQ_ACCUMULATE) && in_range;
               valid_set   = (kind_ff == REQ_ACCUMULATE) && in_range;
               valid_clear = (kind_ff == REQ_CLEAR);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-word valid mask
   always_comb begin
      word_valid_in = word_valid_ff;
      priority if (valid_clear) begin
         word_valid_in = '0;
      end else if (valid_set) begin
         word_valid_in[word_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
   end

   // count RAM, one row of lane counters per word
   bmv_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NUM_WORDS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (word_addr),
      .wr_data (row_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (row_rd)
   );

   // parallel lanes
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bmv_lane #(
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .present    (present),
         .count      (row_rd[i*COUNT_BITS +: COUNT_BITS]),
         .data_bit   (data_ff[i]),
         .threshold  (threshold),
         .count_next (row_wr[i*COUNT_BITS +: COUNT_BITS]),
         .vote       (lane_vote[i])
      );
   end

   // response information for the merge stage
   always_comb begin
      info.word_echo = word_ff;
      info.status    = (kind_ff == REQ_INVALID) ? STATUS_BAD_KIND : STATUS_OK;
      info.vote_en   = (kind_ff == REQ_THRESHOLD) && in_range;
   end

   bmv_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .info       (info),
      .lane_vote  (lane_vote),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/core/bmv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_checker - port level checks of the majority vote bundler
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module bmv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bmv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic [0:0]                         rsp_tuser
);
   import bmv_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a bad request kind never carries vote bits
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == STATUS_BAD_KIND) |->
         rsp_tdata[RSP_VOTE_LSB +: DATA_BITS] == '0)
      else $error("vote bits on a bad request");

   // one request at a time: ready drops after a request transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in work");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind bitwise_majority_vote_top bmv_checker u_checker (.*);
